/* rtl/core/nstp_pkg.sv */
// Package for the note sequence tone player: kind codes, state encoding,
// controller/datapath command and status structs, note tables and helpers.
// No dependencies.
package nstp_pkg;

   localparam int CYCLES_W = 19;   // widest base period is below 2**19
   localparam int NUM_NOTES = 12;

   typedef enum logic [1:0] {
      KIND_LOAD  = 2'd0,
      KIND_START = 2'd1,
      KIND_TICK  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CHECK,
      ST_TONE
   } state_type;

   typedef enum logic [1:0] {
      PRE_DIV1   = 2'd0,
      PRE_DIV8   = 2'd1,
      PRE_DIV64  = 2'd2,
      PRE_DIV256 = 2'd3
   } prescale_type;

   typedef struct packed {
      logic store_wr;
      logic pos_clear;
      logic pos_inc;
      logic beats_dec;
      logic rd_en;
      logic entry_take;   // load hold count, mark playing, register tone stage 1
      logic emit_note;
      logic emit_done;
   } dp_cmd_type;

   typedef struct packed {
      logic at_end;
      logic hold_nz;
      logic playing;
      logic beats_gt1;
   } dp_status_type;

   typedef struct packed {
      logic                found;
      logic [CYCLES_W-1:0] cycles;
   } tone_base_type;

   localparam logic [7:0] NOTE_NAMES [NUM_NOTES] = '{
      8'h43, 8'h64, 8'h44, 8'h65, 8'h45, 8'h46,
      8'h67, 8'h47, 8'h61, 8'h41, 8'h62, 8'h42
   };

   localparam logic [CYCLES_W-1:0] BASE_PERIOD [NUM_NOTES] = '{
      19'd489297, 19'd461760, 19'd435849, 19'd411417, 19'd388350, 19'd366552,
      19'd345946, 19'd326531, 19'd308226, 19'd290909, 19'd274584, 19'd259151
   };

   localparam logic [7:0] HOLD_BIAS = 8'd48;

   function automatic tone_base_type note_lookup(input logic [7:0] c);
      tone_base_type r;
      r = '0;
      for (int i = 0; i < NUM_NOTES; i++) begin
         if (NOTE_NAMES[i] == c) begin
            r.found  = 1'b1;
            r.cycles = BASE_PERIOD[i];
         end
      end
      return r;
   endfunction

   // '0'-'9' -> 0-9, 'a'-'w' / 'A'-'W' -> 10-32, anything else 0
   function automatic logic [5:0] octave_value(input logic [7:0] c);
      logic [7:0] t;
      t = 8'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         t = c - 8'h30;
      end else if (c >= 8'h61 && c <= 8'h77) begin
         t = c - 8'h57;
      end else if (c >= 8'h41 && c <= 8'h57) begin
         t = c - 8'h37;
      end
      return t[5:0];
   endfunction

endpackage

/* rtl/core/nstp_ctrl.sv */
// Controller for the note sequence tone player: command decode and the
// playback walk state machine. Depends on nstp_pkg.
module nstp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_start,
   input  logic [1:0]              req_kind,
   output logic                    busy,
   input  nstp_pkg::dp_status_type status,
   output nstp_pkg::dp_cmd_type    cmd
);
   import nstp_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_start) begin
               unique case (req_kind)
                  KIND_LOAD: begin
                     cmd.store_wr = 1'b1;
                  end
                  KIND_START: begin
                     cmd.pos_clear = 1'b1;
                     state_in      = ST_SCAN;
                  end
                  KIND_TICK: begin
                     if (status.playing) begin
                        if (status.beats_gt1) begin
                           cmd.beats_dec = 1'b1;
                        end else begin
                           cmd.pos_inc = 1'b1;
                           state_in    = ST_SCAN;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (status.at_end) begin
               cmd.emit_done = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.hold_nz) begin
               cmd.entry_take = 1'b1;
               state_in       = ST_TONE;
            end else begin
               cmd.pos_inc = 1'b1;
               state_in    = ST_SCAN;
            end
         end
         ST_TONE: begin
            cmd.emit_note = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   a_start_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (req_start && !busy && req_kind == KIND_START) |=> busy)
      else $error("start transaction did not enter the walk");

   a_one_emit: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.emit_note, cmd.emit_done, cmd.rd_en, cmd.store_wr}))
      else $error("conflicting datapath commands");

endmodule

/* rtl/core/nstp_dpath.sv */
// Datapath for the note sequence tone player: song store, position and
// hold counters, two-stage tone calculation, result and CSR registers.
// Depends on nstp_pkg.
module nstp_dpath #(
   parameter int SONG_DEPTH = 128
) (
   input  logic                    clock,
   input  logic                    reset,
   input  nstp_pkg::dp_cmd_type    cmd,
   output nstp_pkg::dp_status_type status,
   input  logic [6:0]              req_entry_index,
   input  logic [7:0]              req_note_char,
   input  logic [7:0]              req_octave_char,
   input  logic [7:0]              req_hold_char,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [7:0]              csr_data,
   output logic                    rsp_strobe,
   output logic                    rsp_silent,
   output logic [1:0]              rsp_prescaler,
   output logic [15:0]             rsp_period,
   output logic [14:0]             rsp_compare,
   output logic [6:0]              rsp_note_index,
   output logic                    rsp_done_res
);
   import nstp_pkg::*;

   localparam int AW = (SONG_DEPTH > 1) ? $clog2(SONG_DEPTH) : 1;
   localparam int PW = $clog2(SONG_DEPTH + 1);
   localparam int EW = (PW > 8) ? PW : 8;
   localparam int XW = (PW > 7) ? PW : 7;

   // song store: {note, octave, hold}
   logic [23:0]          store_mem [SONG_DEPTH];
   logic [23:0]          rd_data_ff;

   logic [7:0]           song_length_ff;
   logic [PW-1:0]        pos_ff;
   logic [7:0]           beats_ff;
   logic                 playing_ff;

   logic                 tone_found_ff;
   logic [CYCLES_W-1:0]  tone_cycles_ff;

   logic                 strobe_ff;
   logic                 silent_ff;
   logic [1:0]           pre_ff;
   logic [15:0]          period_ff;
   logic [14:0]          compare_ff;
   logic [6:0]           index_ff;
   logic                 done_ff;

   logic                 idx_ok;
   logic [AW-1:0]        wr_addr;
   logic [EW-1:0]        len_ext;
   logic [EW-1:0]        song_end;
   logic [7:0]           rd_hold;
   tone_base_type        base;
   logic [5:0]           oct;
   logic [4:0]           oct_shift;
   prescale_type         pre_in;
   logic [3:0]           div_shift;
   logic [CYCLES_W-1:0]  per_full;
   logic [15:0]          per_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         song_length_ff <= '0;
      end else if (csr_valid) begin
         song_length_ff <= csr_data;
      end
   end

   // loads beyond the store are dropped
   assign idx_ok  = XW'(req_entry_index) < XW'(SONG_DEPTH);
   assign wr_addr = AW'(req_entry_index);

   always_ff @(posedge clock) begin
      if (cmd.store_wr && idx_ok) begin
         store_mem[wr_addr] <= {req_note_char, req_octave_char, req_hold_char};
      end
      if (cmd.rd_en) begin
         rd_data_ff <= store_mem[pos_ff[AW-1:0]];
      end
   end

   assign len_ext  = EW'(song_length_ff);
   assign song_end = (len_ext > EW'(SONG_DEPTH)) ? EW'(SONG_DEPTH) : len_ext;
   assign rd_hold  = rd_data_ff[7:0];

   assign status.at_end    = EW'(pos_ff) >= song_end;
   assign status.hold_nz   = rd_hold > HOLD_BIAS;
   assign status.playing   = playing_ff;
   assign status.beats_gt1 = beats_ff > 8'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         beats_ff   <= '0;
         playing_ff <= 1'b0;
      end else begin
         if (cmd.pos_clear) begin
            pos_ff <= '0;
         end else if (cmd.pos_inc) begin
            pos_ff <= pos_ff + PW'(1);
         end
         if (cmd.entry_take) begin
            beats_ff   <= rd_hold - HOLD_BIAS;
            playing_ff <= 1'b1;
         end else if (cmd.beats_dec) begin
            beats_ff <= beats_ff - 8'd1;
         end else if (cmd.emit_done) begin
            beats_ff   <= '0;
            playing_ff <= 1'b0;
         end
      end
   end

   // tone stage 1: base period lookup and octave shift
   assign base      = note_lookup(rd_data_ff[23:16]);
   assign oct       = octave_value(rd_data_ff[15:8]);
   assign oct_shift = (oct > 6'd1) ? 5'(oct - 6'd1) : 5'd0;

   always_ff @(posedge clock) begin
      if (cmd.entry_take) begin
         tone_found_ff  <= base.found;
         tone_cycles_ff <= base.cycles >> oct_shift;
      end
   end

   // tone stage 2: prescaler pick, period and compare
   always_comb begin
      if (tone_cycles_ff < CYCLES_W'(17'h10000)) begin
         pre_in    = PRE_DIV1;
         div_shift = 4'd0;
      end else if ((tone_cycles_ff >> 3) < CYCLES_W'(17'h10000)) begin
         pre_in    = PRE_DIV8;
         div_shift = 4'd3;
      end else if ((tone_cycles_ff >> 6) < CYCLES_W'(17'h10000)) begin
         pre_in    = PRE_DIV64;
         div_shift = 4'd6;
      end else begin
         pre_in    = PRE_DIV256;
         div_shift = 4'd8;
      end
      per_full = tone_cycles_ff >> div_shift;
      per_in   = (per_full == '0) ? 16'd0 : 16'(per_full - CYCLES_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit_note || cmd.emit_done;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_done) begin
         silent_ff  <= 1'b0;
         pre_ff     <= '0;
         period_ff  <= '0;
         compare_ff <= '0;
         index_ff   <= '0;
         done_ff    <= 1'b1;
      end else if (cmd.emit_note) begin
         silent_ff  <= !tone_found_ff;
         pre_ff     <= tone_found_ff ? pre_in : PRE_DIV1;
         period_ff  <= tone_found_ff ? per_in : 16'd0;
         compare_ff <= tone_found_ff ? per_in[15:1] : 15'd0;
         index_ff   <= 7'(pos_ff);
         done_ff    <= 1'b0;
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_silent     = silent_ff;
   assign rsp_prescaler  = pre_ff;
   assign rsp_period     = period_ff;
   assign rsp_compare    = compare_ff;
   assign rsp_note_index = index_ff;
   assign rsp_done_res   = done_ff;

   a_playing_has_beats: assert property (@(posedge clock) disable iff (reset)
      playing_ff |-> (beats_ff != 8'd0))
      else $error("playing with no beats left");

   a_done_clean: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && done_ff) |-> (!silent_ff && period_ff == 16'd0 && index_ff == 7'd0))
      else $error("song end result carries data");

   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |=> !strobe_ff)
      else $error("result strobe held for two cycles");

endmodule

/* rtl/core/note_sequence_tone_player.sv */
// Note sequence tone player: plays a stored song as square-wave timer settings.
// Load and plain beat ticks finish while busy stays low. A start, or a tick
//   that ends a note, walks the song store slot by slot through SCAN and CHECK,
//   skips zero-hold slots, and strobes after SCAN at song end or after TONE.
// One walk at a time: commands are only taken while idle, and the store has a
//   single registered read port. Results cannot be stalled by the receiver.
// Reset (synchronous): idle, not playing, song_length 0; store contents undefined.
module note_sequence_tone_player #(
   parameter int SONG_DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   // command channel
   input  logic        req_start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [6:0]  req_entry_index,
   input  logic [7:0]  req_note_char,
   input  logic [7:0]  req_octave_char,
   input  logic [7:0]  req_hold_char,
   // result channel, one-cycle strobe
   output logic        rsp_strobe,
   output logic        rsp_silent,
   output logic [1:0]  rsp_prescaler,
   output logic [15:0] rsp_period,
   output logic [14:0] rsp_compare,
   output logic [6:0]  rsp_note_index,
   output logic        rsp_done_res,
   // song_length register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);
   import nstp_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // controller: decodes each transaction and sequences the store walk
   nstp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_start (req_start),
      .req_kind  (req_kind),
      .busy      (busy),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: store, counters, tone maths and result registers
   nstp_dpath #(
      .SONG_DEPTH (SONG_DEPTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_entry_index (req_entry_index),
      .req_note_char   (req_note_char),
      .req_octave_char (req_octave_char),
      .req_hold_char   (req_hold_char),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .rsp_strobe      (rsp_strobe),
      .rsp_silent      (rsp_silent),
      .rsp_prescaler   (rsp_prescaler),
      .rsp_period      (rsp_period),
      .rsp_compare     (rsp_compare),
      .rsp_note_index  (rsp_note_index),
      .rsp_done_res    (rsp_done_res)
   );

   // a result only ever follows a walk, never a bare load or tick
   a_strobe_after_walk: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result without a preceding walk");

endmodule

/* tb/note_sequence_tone_player_tb.sv */
// Self-checking testbench for note_sequence_tone_player: directed plan, then
// randomised song traffic, every result checked against an in-bench predictor.
// Depends on nstp_pkg and the note_sequence_tone_player RTL only.
module note_sequence_tone_player_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import nstp_pkg::*;

   localparam int          SONG_SLOTS   = 128;
   localparam int          RANDOM_ITEMS = 1450;   // directed plan brings the rest
   localparam int          CFG_SETTLE   = 6;      // loads and plain ticks finish while busy stays low
   localparam int          END_SETTLE   = 300;    // longest walk visits all 128 slots
   localparam longint      CYCLE_LIMIT  = 2_000_000;
   localparam int          REPORT_MAX   = 10;
   localparam logic [1:0]  KIND_UNUSED  = 2'd3;   // no operation behind this code
   localparam logic [7:0]  REST_CHAR    = 8'h20;
   localparam logic [7:0]  HOLD_ZERO    = 8'h30;  // '0' beats

   // Note letters and their base cycle counts, lowest pitch first
   localparam logic [7:0] TONE_NAMES [12] = '{
      "C", "d", "D", "e", "E", "F", "g", "G", "a", "A", "b", "B"
   };
   localparam int unsigned TONE_CYCLES [12] = '{
      489297, 461760, 435849, 411417, 388350, 366552,
      345946, 326531, 308226, 290909, 274584, 259151
   };

   typedef struct packed {
      logic [1:0] kind;
      logic [6:0] entry_index;
      logic [7:0] note_char;
      logic [7:0] octave_char;
      logic [7:0] hold_char;
   } tone_req_type;

   typedef struct packed {
      logic         silent;
      prescale_type prescaler;
      logic [15:0]  period;
      logic [14:0]  compare;
      logic [6:0]   note_index;
      logic         done_res;
   } tone_rsp_type;

   typedef enum logic [1:0] {
      ROW_ITEM,
      ROW_CFG,
      ROW_FILL
   } row_act_type;

   // One line of the directed plan; want is used only where typed is set
   typedef struct packed {
      row_act_type  act;
      tone_req_type req;
      logic [7:0]   song_len;
      logic         typed;
      tone_rsp_type want;
   } plan_row_type;

   // ---------------------------------------------------------------- DUT side
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_start = 1'b0;
   logic        busy;
   logic [1:0]  req_kind = '0;
   logic [6:0]  req_entry_index = '0;
   logic [7:0]  req_note_char = '0;
   logic [7:0]  req_octave_char = '0;
   logic [7:0]  req_hold_char = '0;
   logic        rsp_strobe;
   logic        rsp_silent;
   logic [1:0]  rsp_prescaler;
   logic [15:0] rsp_period;
   logic [14:0] rsp_compare;
   logic [6:0]  rsp_note_index;
   logic        rsp_done_res;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data = '0;

   note_sequence_tone_player #(
      .SONG_DEPTH (SONG_SLOTS)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_start       (req_start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_entry_index (req_entry_index),
      .req_note_char   (req_note_char),
      .req_octave_char (req_octave_char),
      .req_hold_char   (req_hold_char),
      .rsp_strobe      (rsp_strobe),
      .rsp_silent      (rsp_silent),
      .rsp_prescaler   (rsp_prescaler),
      .rsp_period      (rsp_period),
      .rsp_compare     (rsp_compare),
      .rsp_note_index  (rsp_note_index),
      .rsp_done_res    (rsp_done_res),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data)
   );

   initial forever #6 clock = ~clock;

   // ------------------------------------------------------- predictor state
   // Own copy of the song store, play pointer and length register. Every
   // slot is written by the fill pass before any walk can reach it.
   logic [7:0]  song_notes   [SONG_SLOTS];
   logic [7:0]  song_octaves [SONG_SLOTS];
   logic [7:0]  song_holds   [SONG_SLOTS];
   logic [7:0]  song_len_reg = '0;
   int unsigned cue_pos = 0;
   int unsigned beats_remaining = 0;
   bit          is_playing = 1'b0;

   tone_rsp_type tones_due [$];    // settings still owed by the block, oldest first
   int           fault_count = 0;
   longint       cycle_count = 0;

   // '0'-'9' give 0-9, 'a'-'w' and 'A'-'W' give 10-32, anything else 0
   function automatic int unsigned octave_num(input logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "w") return c - "a" + 10;
      if (c >= "A" && c <= "W") return c - "A" + 10;
      return 0;
   endfunction

   function automatic int unsigned hold_beats(input logic [7:0] c);
      return (c >= 8'd48) ? c - 8'd48 : 0;
   endfunction

   // Timer setting for one stored note
   function automatic tone_rsp_type tone_setting(input int unsigned slot);
      tone_rsp_type s;
      int unsigned  cyc;
      int unsigned  div;
      int unsigned  per;
      int unsigned  oct;
      bit           hit;
      s   = '0;
      cyc = 0;
      hit = 1'b0;
      s.note_index = 7'(slot);
      for (int i = 0; i < 12; i++) begin
         if (TONE_NAMES[i] == song_notes[slot]) begin
            cyc = TONE_CYCLES[i];
            hit = 1'b1;
         end
      end
      // rest or unrecognised letter: muted, timer fields left at zero
      if (!hit) begin
         s.silent = 1'b1;
         return s;
      end
      oct = octave_num(song_octaves[slot]);
      if (oct > 1) begin
         cyc = (oct - 1 >= 32) ? 0 : cyc >> (oct - 1);
      end
      // smallest prescaler that brings the count under 16 bits
      if (cyc < 65536) begin
         s.prescaler = PRE_DIV1;
         div = 1;
      end else if (cyc / 8 < 65536) begin
         s.prescaler = PRE_DIV8;
         div = 8;
      end else if (cyc / 64 < 65536) begin
         s.prescaler = PRE_DIV64;
         div = 64;
      end else begin
         s.prescaler = PRE_DIV256;
         div = 256;
      end
      per = cyc / div;
      if (per != 0) begin
         per--;
      end
      s.period  = 16'(per);
      s.compare = 15'(per / 2);
      return s;
   endfunction

   // Skip zero-hold slots from first_slot on; emit the next note or song end
   function automatic tone_rsp_type walk_song(input int unsigned first_slot);
      int unsigned  last;
      tone_rsp_type s;
      last = (song_len_reg > SONG_SLOTS) ? SONG_SLOTS : song_len_reg;
      for (int unsigned p = first_slot; p < last; p++) begin
         if (hold_beats(song_holds[p]) != 0) begin
            cue_pos         = p;
            beats_remaining = hold_beats(song_holds[p]);
            is_playing      = 1'b1;
            return tone_setting(p);
         end
      end
      cue_pos         = last;
      beats_remaining = 0;
      is_playing      = 1'b0;
      s          = '0;
      s.done_res = 1'b1;
      return s;
   endfunction

   // Advance the predictor by one accepted transaction; 1 if a setting is owed
   function automatic bit predict_tone(input tone_req_type r, output tone_rsp_type e);
      e = '0;
      case (r.kind)
         KIND_LOAD: begin
            song_notes[r.entry_index]   = r.note_char;
            song_octaves[r.entry_index] = r.octave_char;
            song_holds[r.entry_index]   = r.hold_char;
            return 1'b0;
         end
         KIND_START: begin
            e = walk_song(0);
            return 1'b1;
         end
         KIND_TICK: begin
            if (!is_playing) return 1'b0;
            if (beats_remaining > 1) begin
               beats_remaining--;
               return 1'b0;
            end
            beats_remaining = 0;
            e = walk_song(cue_pos + 1);
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // ------------------------------------------------------- plan builders
   function automatic tone_rsp_type tone(input logic silent, input prescale_type pre,
                                         input logic [15:0] per, input logic [14:0] cmp,
                                         input logic [6:0] idx, input logic done);
      tone_rsp_type s;
      s.silent     = silent;
      s.prescaler  = pre;
      s.period     = per;
      s.compare    = cmp;
      s.note_index = idx;
      s.done_res   = done;
      return s;
   endfunction

   function automatic plan_row_type op_row(input logic [1:0] kind, input logic [6:0] idx,
                                           input logic [7:0] note, input logic [7:0] oct,
                                           input logic [7:0] hold);
      plan_row_type w;
      w                 = '0;
      w.act             = ROW_ITEM;
      w.req.kind        = kind;
      w.req.entry_index = idx;
      w.req.note_char   = note;
      w.req.octave_char = oct;
      w.req.hold_char   = hold;
      return w;
   endfunction

   function automatic plan_row_type op_expect(input logic [1:0] kind,
                                              input tone_rsp_type want);
      plan_row_type w;
      w          = op_row(kind, '0, '0, '0, '0);
      w.typed    = 1'b1;
      w.want     = want;
      return w;
   endfunction

   function automatic plan_row_type cfg_row(input logic [7:0] len);
      plan_row_type w;
      w          = '0;
      w.act      = ROW_CFG;
      w.song_len = len;
      return w;
   endfunction

   // Mostly back-to-back, some short gaps, the odd long one
   function automatic int unsigned random_gap(input bit quiet);
      int unsigned k;
      if (quiet) return 0;
      k = $urandom_range(0, 99);
      if (k < 65) return 0;
      if (k < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // ------------------------------------------------------- drivers
   task automatic pause_sender(input int unsigned n);
      if (n > 0) begin
         req_start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Present one transaction and hold it until the edge that accepts it.
   // req_start stays high on return so the next one can follow at once.
   task automatic send_item(input tone_req_type r, input logic typed,
                            input tone_rsp_type want);
      tone_rsp_type e;
      req_kind        <= r.kind;
      req_entry_index <= r.entry_index;
      req_note_char   <= r.note_char;
      req_octave_char <= r.octave_char;
      req_hold_char   <= r.hold_char;
      req_start       <= 1'b1;
      do @(posedge clock); while (busy);
      if (predict_tone(r, e)) begin
         tones_due.push_back(typed ? want : e);
      end
   endtask

   // Stop sending and wait until every owed setting has come, then settle
   task automatic drain_results(input int unsigned settle);
      req_start <= 1'b0;
      do @(posedge clock); while (tones_due.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_song_length(input logic [7:0] len);
      repeat ($urandom_range(0, 3)) @(posedge clock);
      csr_data  <= len;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid    <= 1'b0;
      song_len_reg  = len;
   endtask

   task automatic note_fault(input string what, input tone_rsp_type due,
                             input tone_rsp_type seen);
      fault_count++;
      if (fault_count <= REPORT_MAX) begin
         $display("%0t %s: expected sil=%0d pre=%0d per=%0d cmp=%0d idx=%0d done=%0d",
                  $time, what, due.silent, due.prescaler, due.period, due.compare,
                  due.note_index, due.done_res);
         $display("%0t %s: actual   sil=%0d pre=%0d per=%0d cmp=%0d idx=%0d done=%0d",
                  $time, what, seen.silent, seen.prescaler, seen.period, seen.compare,
                  seen.note_index, seen.done_res);
      end
   endtask

   // ------------------------------------------------------- result checking
   // The strobe lasts one cycle and cannot be held off, so every strobed
   // transaction is taken at the edge that closes it.
   always @(posedge clock) begin : result_check
      tone_rsp_type seen;
      tone_rsp_type due;
      if (!reset && rsp_strobe) begin
         seen.silent     = rsp_silent;
         seen.prescaler  = prescale_type'(rsp_prescaler);
         seen.period     = rsp_period;
         seen.compare    = rsp_compare;
         seen.note_index = rsp_note_index;
         seen.done_res   = rsp_done_res;
         if (tones_due.size() == 0) begin
            note_fault("unexpected result", '0, seen);
         end else begin
            due = tones_due.pop_front();
            if (seen.silent !== due.silent || seen.prescaler !== due.prescaler ||
                seen.period !== due.period || seen.compare !== due.compare ||
                seen.note_index !== due.note_index || seen.done_res !== due.done_res) begin
               note_fault("result mismatch", due, seen);
            end
         end
      end
   end

   // Watchdog: bound on the slowest legal run, several times over
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------- stimulus
   initial begin : stimulus
      plan_row_type plan [$];
      plan_row_type row;
      tone_req_type r;
      tone_rsp_type song_over;
      tone_rsp_type c1_first;
      int unsigned  counted;
      int unsigned  phase_items;
      int unsigned  top;
      int unsigned  sel;
      int unsigned  k;
      logic [7:0]   len;
      bit           quiet;

      song_over = tone(1'b0, PRE_DIV1, 16'd0, 15'd0, 7'd0, 1'b1);
      // 'C' octave 1: 489297 / 8 = 61162, minus one, halved
      c1_first  = tone(1'b0, PRE_DIV8, 16'd61161, 15'd30580, 7'd0, 1'b0);

      // Straight after reset: length 0, so a start ends the song at once
      plan.push_back(op_expect(KIND_START, song_over));
      plan.push_back(op_row(KIND_TICK, 7'd0, 8'h00, 8'h00, 8'h00));       // idle tick
      plan.push_back(op_row(KIND_UNUSED, 7'h7f, 8'hff, 8'hff, 8'hff));    // dead code
      row     = '0;
      row.act = ROW_FILL;
      plan.push_back(row);
      plan.push_back(cfg_row(8'd128));
      plan.push_back(op_expect(KIND_START, song_over));    // every slot zero-hold
      plan.push_back(op_row(KIND_LOAD, 7'd0, "C", "1", "1"));
      plan.push_back(op_expect(KIND_START, c1_first));
      plan.push_back(op_expect(KIND_TICK, song_over));
      plan.push_back(op_row(KIND_LOAD, 7'd1, REST_CHAR, "5", "2"));
      plan.push_back(op_expect(KIND_START, c1_first));
      plan.push_back(op_expect(KIND_TICK, tone(1'b1, PRE_DIV1, 16'd0, 15'd0, 7'd1, 1'b0)));
      plan.push_back(op_row(KIND_TICK, 7'd0, 8'h00, 8'h00, 8'h00));      // 2 beats -> 1
      plan.push_back(op_expect(KIND_TICK, song_over));
      plan.push_back(op_row(KIND_LOAD, 7'd1, "A", "0", "1"));            // octave 0: no shift
      plan.push_back(op_row(KIND_LOAD, 7'd2, "B", "W", "1"));            // octave 32 shifts to 0
      plan.push_back(op_row(KIND_LOAD, 7'd3, 8'hff, 8'hff, 8'hff));      // bad letter, max hold
      plan.push_back(op_expect(KIND_START, c1_first));
      plan.push_back(op_expect(KIND_TICK,
                               tone(1'b0, PRE_DIV8, 16'd36362, 15'd18181, 7'd1, 1'b0)));
      plan.push_back(op_expect(KIND_TICK, tone(1'b0, PRE_DIV1, 16'd0, 15'd0, 7'd2, 1'b0)));
      plan.push_back(op_expect(KIND_TICK, tone(1'b1, PRE_DIV1, 16'd0, 15'd0, 7'd3, 1'b0)));
      plan.push_back(op_row(KIND_LOAD, 7'd127, "g", "w", "A"));          // load mid-song
      plan.push_back(op_expect(KIND_START, c1_first));                   // restart mid-song
      plan.push_back(op_row(KIND_LOAD, 7'd4, 8'h00, 8'h00, 8'h00));
      plan.push_back(cfg_row(8'd200));                                    // clamps to 128
      plan.push_back(op_expect(KIND_START, c1_first));
      plan.push_back(cfg_row(8'd0));
      plan.push_back(op_expect(KIND_TICK, song_over));                   // end already passed

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed plan
      foreach (plan[i]) begin
         row = plan[i];
         case (row.act)
            ROW_CFG: begin
               drain_results(CFG_SETTLE);
               write_song_length(row.song_len);
            end
            ROW_FILL: begin
               // write every slot once, all zero-hold, so no walk reads junk
               for (int s = 0; s < SONG_SLOTS; s++) begin
                  r.kind        = KIND_LOAD;
                  r.entry_index = 7'(s);
                  r.note_char   = 8'($urandom);
                  r.octave_char = 8'($urandom);
                  r.hold_char   = 8'($urandom_range(0, 48));
                  pause_sender(random_gap(1'b0));
                  send_item(r, 1'b0, '0);
               end
            end
            default: begin
               pause_sender(random_gap(1'b0));
               send_item(row.req, row.typed, row.want);
            end
         endcase
      end

      // Random phases: new song length, then a burst of song traffic
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         k = $urandom_range(0, 19);
         if (k == 0) len = 8'd0;
         else if (k == 1) len = 8'd128;
         else if (k == 2) len = 8'($urandom_range(129, 255));
         else if (k < 6) len = 8'($urandom_range(17, 127));
         else len = 8'($urandom_range(1, 16));
         drain_results(CFG_SETTLE);
         write_song_length(len);
         top         = (len == 0) ? 1 : ((len > SONG_SLOTS) ? SONG_SLOTS : len);
         quiet       = ($urandom_range(0, 3) == 0);    // a phase with no gaps
         phase_items = $urandom_range(40, 120);

         for (int n = 0; n < phase_items; n++) begin
            // noise everywhere first, then shape the well-formed kinds
            r.kind        = 2'($urandom);
            r.entry_index = 7'($urandom);
            r.note_char   = 8'($urandom);
            r.octave_char = 8'($urandom);
            r.hold_char   = 8'($urandom);
            sel = $urandom_range(0, 99);
            if (sel < 22) begin
               r.kind = KIND_LOAD;
               if ($urandom_range(0, 4) != 0) begin
                  r.entry_index = 7'($urandom_range(0, top - 1));
               end
               k = $urandom_range(0, 12);
               if ($urandom_range(0, 19) > 2) begin
                  r.note_char = (k == 12) ? REST_CHAR : TONE_NAMES[k];
               end
               k = $urandom_range(0, 32);
               if ($urandom_range(0, 19) > 2) begin
                  if (k < 10) r.octave_char = 8'(8'h30 + k);
                  else if ($urandom_range(0, 1)) r.octave_char = 8'(8'h61 + k - 10);
                  else r.octave_char = 8'(8'h41 + k - 10);
               end
               // short holds keep the song moving; zero and odd holds now and then
               k = $urandom_range(0, 99);
               if (k < 72) r.hold_char = 8'(8'h31 + $urandom_range(0, 2));
               else if (k < 82) r.hold_char = HOLD_ZERO;
               else if (k < 93) r.hold_char = 8'($urandom_range(0, 47));
            end else if (sel < 30) begin
               r.kind = KIND_START;
            end else if (sel < 94) begin
               r.kind = KIND_TICK;
            end else if (sel < 97) begin
               r.kind = KIND_UNUSED;
            end

            counted++;
            if ($urandom_range(0, 39) == 0) begin
               drain_results(0);       // hold off until the block has caught up
            end
            pause_sender(random_gap(quiet));
            send_item(r, 1'b0, '0);
         end
      end

      drain_results(END_SETTLE);
      if (fault_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
